FILE: src/assert_macros.svh
// assertion macros shared by the checker of the vertex index dedup block
// no dependencies; clock and reset are taken from the enclosing module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every rising edge outside reset
`define VID_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked on every rising edge, reset included
`define VID_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: src/vid_pkg.sv
// shared types, constants and hash function of the vertex index dedup block
// no dependencies
package vid_pkg;

  // table depth, a power of two
  localparam int TABLE_ENTRIES = 1024;
  localparam int INDEX_BITS    = 20;
  localparam int FIELD_W       = 20;
  localparam int NUM_W         = 10;
  localparam int SLOT_W        = $clog2(TABLE_ENTRIES);
  localparam int COUNT_W       = SLOT_W + 1;
  // mesh generation tag kept beside each entry, zero marks a cleared entry
  localparam int EPOCH_W       = 8;

  localparam int IN_TDATA_W    = 64;
  localparam int IN_TUSER_W    = 1;
  localparam int OUT_TDATA_W   = 72;
  localparam int OUT_TUSER_W   = 2;
  localparam int IN_PAD_W      = IN_TDATA_W - 3 * FIELD_W;
  localparam int OUT_PAD_W     = OUT_TDATA_W - NUM_W - 3 * FIELD_W;

  localparam logic [SLOT_W-1:0]  SLOT_LAST = SLOT_W'(TABLE_ENTRIES - 1);
  localparam logic [EPOCH_W-1:0] EPOCH_MAX = '1;
  localparam logic [EPOCH_W-1:0] EPOCH_ONE = EPOCH_W'(1);
  localparam logic [EPOCH_W-1:0] EPOCH_CLR = '0;

  // output tuser bits
  localparam int USER_IS_NEW = 0;
  localparam int USER_FULL   = 1;

  typedef struct packed {
    logic [INDEX_BITS-1:0] nrm;
    logic [INDEX_BITS-1:0] tex;
    logic [INDEX_BITS-1:0] pos;
  } key_t;

  typedef struct packed {
    logic [EPOCH_W-1:0] epoch;
    key_t               key;
    logic [NUM_W-1:0]   number;
  } entry_t;

  typedef enum logic [2:0] {
    ST_INIT_CLEAR,
    ST_IDLE,
    ST_MESH_CLEAR,
    ST_REREAD,
    ST_PROBE
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic new_epoch;
    logic sweep;
    logic reread;
    logic step;
    logic finish;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic hit;
    logic empty;
    logic probe_last;
    logic sweep_last;
    logic epoch_wrap;
    logic out_free;
  } sts_t;

  function automatic logic [SLOT_W-1:0] home_slot(input key_t k);
    logic [INDEX_BITS-1:0] x;
    x = k.pos ^ k.tex ^ k.nrm;
    return SLOT_W'(x);
  endfunction

endpackage

FILE: src/vid_datapath.sv
// datapath of the vertex index dedup block: entry memory, probe pointer,
// mesh tag, vertex counter and output register; uses vid_pkg
module vid_datapath import vid_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cmd_t                   cmd_i,
  output sts_t                   sts_o,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // pos, tex, nrm, zero pad
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // number, gather pos, tex, nrm, pad
  output logic [OUT_TUSER_W-1:0] m_axis_tuser    // is_new, table_full
);

  entry_t mem_q [TABLE_ENTRIES];
  entry_t rd_q;

  key_t               in_key;
  key_t               key_q;
  logic [SLOT_W-1:0]  slot_q, slot_d;
  logic [SLOT_W-1:0]  probe_q;
  logic [SLOT_W-1:0]  sweep_q;
  logic [EPOCH_W-1:0] epoch_q;
  logic [COUNT_W-1:0] count_q;

  logic               rd_en;
  logic               wr_en;
  logic [SLOT_W-1:0]  wr_addr;
  entry_t             wr_data;
  logic               valid, hit, empty;

  logic               m_valid_q;
  logic [NUM_W-1:0]   num_q;
  logic               is_new_q, full_q;
  logic [FIELD_W-1:0] gpos_q, gtex_q, gnrm_q;

  assign in_key.pos = INDEX_BITS'(s_axis_tdata[FIELD_W-1:0]);
  assign in_key.tex = INDEX_BITS'(s_axis_tdata[2*FIELD_W-1:FIELD_W]);
  assign in_key.nrm = INDEX_BITS'(s_axis_tdata[3*FIELD_W-1:2*FIELD_W]);

  always_comb begin
    slot_d = slot_q;
    if (cmd_i.load) begin
      slot_d = home_slot(in_key);
    end else if (cmd_i.step) begin
      slot_d = (slot_q == SLOT_LAST) ? '0 : slot_q + SLOT_W'(1);
    end
  end

  assign rd_en = cmd_i.load | cmd_i.step | cmd_i.reread;

  assign valid = (rd_q.epoch == epoch_q);
  assign hit   = valid && (rd_q.key == key_q);
  assign empty = !valid;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = slot_q;
    wr_data = '{epoch: epoch_q, key: key_q, number: NUM_W'(count_q)};
    if (cmd_i.sweep) begin
      wr_en   = 1'b1;
      wr_addr = sweep_q;
      wr_data = '{epoch: EPOCH_CLR, key: '0, number: '0};
    end else if (cmd_i.finish && empty) begin
      wr_en = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem_q[slot_d];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      key_q <= in_key;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q  <= '0;
      probe_q <= '0;
      sweep_q <= '0;
      epoch_q <= EPOCH_ONE;
      count_q <= '0;
    end else begin
      slot_q <= slot_d;
      if (cmd_i.load) begin
        probe_q <= '0;
      end else if (cmd_i.step) begin
        probe_q <= probe_q + SLOT_W'(1);
      end
      if (cmd_i.sweep) begin
        sweep_q <= (sweep_q == SLOT_LAST) ? '0 : sweep_q + SLOT_W'(1);
      end
      if (cmd_i.new_epoch) begin
        epoch_q <= (epoch_q == EPOCH_MAX) ? EPOCH_ONE : epoch_q + EPOCH_ONE;
        count_q <= '0;
      end else if (cmd_i.finish && empty) begin
        count_q <= count_q + COUNT_W'(1);
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      num_q    <= hit ? rd_q.number : (empty ? NUM_W'(count_q) : '0);
      is_new_q <= empty;
      full_q   <= !hit && !empty;
      gpos_q   <= empty ? FIELD_W'(key_q.pos) : '0;
      gtex_q   <= empty ? FIELD_W'(key_q.tex) : '0;
      gnrm_q   <= empty ? FIELD_W'(key_q.nrm) : '0;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, gnrm_q, gtex_q, gpos_q, num_q};
  always_comb begin
    m_axis_tuser              = '0;
    m_axis_tuser[USER_IS_NEW] = is_new_q;
    m_axis_tuser[USER_FULL]   = full_q;
  end

  assign sts_o.hit        = hit;
  assign sts_o.empty      = empty;
  assign sts_o.probe_last = (probe_q == SLOT_LAST);
  assign sts_o.sweep_last = (sweep_q == SLOT_LAST);
  assign sts_o.epoch_wrap = (epoch_q == EPOCH_MAX);
  assign sts_o.out_free   = !m_valid_q || m_axis_tready;

endmodule

FILE: src/vid_ctrl.sv
// controller of the vertex index dedup block: sweep, accept and probe sequencing
// uses vid_pkg; drives the datapath through cmd_t and reads sts_t
module vid_ctrl import vid_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  input  logic new_mesh_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   resolved;

  assign resolved = sts_i.hit || sts_i.empty || sts_i.probe_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_INIT_CLEAR: begin
        if (sts_i.sweep_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = (new_mesh_i && sts_i.epoch_wrap) ? ST_MESH_CLEAR : ST_PROBE;
        end
      end
      ST_MESH_CLEAR: begin
        if (sts_i.sweep_last) state_d = ST_REREAD;
      end
      ST_REREAD: begin
        state_d = ST_PROBE;
      end
      ST_PROBE: begin
        if (resolved && sts_i.out_free) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_INIT_CLEAR;
      end
    endcase
  end

  // outputs
  always_comb begin
    cmd_o         = '0;
    s_axis_tready = 1'b0;
    case (state_q)
      ST_INIT_CLEAR, ST_MESH_CLEAR: begin
        cmd_o.sweep = 1'b1;
      end
      ST_IDLE: begin
        s_axis_tready   = 1'b1;
        cmd_o.load      = s_axis_tvalid;
        cmd_o.new_epoch = s_axis_tvalid && new_mesh_i;
      end
      ST_REREAD: begin
        cmd_o.reread = 1'b1;
      end
      ST_PROBE: begin
        cmd_o.finish = resolved && sts_i.out_free;
        cmd_o.step   = !resolved;
      end
      default: begin
        cmd_o = '0;
      end
    endcase
  end

endmodule

FILE: src/vertex_index_dedup.sv
// vertex index dedup: maps (position, texcoord, normal) triples to compact
// vertex numbers in first-seen order; uses vid_pkg, vid_ctrl, vid_datapath
//
// usage
// - slave stream carries one face corner per transfer; tdata holds the
//   position, texcoord and normal indices, tuser the new-mesh mark
// - master stream returns one result per corner: the vertex number, the
//   gather indices (only for a first-seen triple), is_new and table_full
// - lookup is a hash of the xor of the three indices into a single-port
//   table with linear probing, one table read per cycle
// timing
// - a corner whose triple sits in its home slot goes through accept and
//   table read, then compare and, for a new triple, write-back; each further probe adds a read
// - result appears in the output register on the edge after the compare;
//   tready drops between the accept and that edge
// - a new_mesh corner bumps the mesh tag that entries must match; every
//   255th new mesh it wraps: a 1024-entry sweep and a reread precede the lookup
// reset
// - after reset a 1024-entry sweep clears the table tags; tready stays low
// stall
// - a result held by a stalled receiver keeps its transfer pending; the
//   block waits in the compare step until the output register is free
module vertex_index_dedup import vid_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // position_index, texcoord_index, normal_index
  input  logic [IN_TUSER_W-1:0]  s_axis_tuser,   // new_mesh
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // vertex_number, gather_position,
                                                 // gather_texcoord, gather_normal
  output logic [OUT_TUSER_W-1:0] m_axis_tuser    // is_new, table_full
);

  cmd_t cmd;
  sts_t sts;

  // sequencer
  vid_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .new_mesh_i    (s_axis_tuser[0]),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  // table, counters and result register
  vid_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

endmodule

FILE: src/vid_checker.sv
// port-level checker of the vertex index dedup block, bound to the top level
// uses vid_pkg and assert_macros.svh
`include "assert_macros.svh"

module vid_checker import vid_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,   // vertex_number, gathers
  input logic [OUT_TUSER_W-1:0] m_axis_tuser    // is_new, table_full
);

  logic                               in_xfer;
  logic                               out_stalled;
  logic                               out_new;
  logic                               out_full;
  logic [NUM_W-1:0]                   out_number;
  logic [OUT_TDATA_W-NUM_W-1:0]       out_gathers;
  logic [OUT_TDATA_W+OUT_TUSER_W-1:0] out_word;

  assign in_xfer     = s_axis_tvalid && s_axis_tready;
  assign out_stalled = m_axis_tvalid && !m_axis_tready;
  assign out_new     = m_axis_tuser[USER_IS_NEW];
  assign out_full    = m_axis_tuser[USER_FULL];
  assign out_number  = m_axis_tdata[NUM_W-1:0];
  assign out_gathers = m_axis_tdata[OUT_TDATA_W-1:NUM_W];
  assign out_word    = {m_axis_tuser, m_axis_tdata};

  // a result is never both new and a full-table miss
  `VID_ASSERT_ALWAYS(a_new_not_full, m_axis_tvalid |-> !(out_new && out_full), "new and full")

  // gather indices only travel with a new triple
  `VID_ASSERT(a_gather_zero, (m_axis_tvalid && !out_new) |-> (out_gathers == '0), "stray gather")

  // a full-table miss reports number zero
  `VID_ASSERT(a_full_number, (m_axis_tvalid && out_full) |-> (out_number == '0), "full number")

  // a stalled result holds
  `VID_ASSERT(a_out_hold, out_stalled |=> (m_axis_tvalid && $stable(out_word)), "result moved")

  // one corner at a time: no transfer on the edge right after another
  `VID_ASSERT(a_one_accept, in_xfer |=> !s_axis_tready, "back to back accept")

endmodule

bind vertex_index_dedup vid_checker u_vid_checker (.*);
